// File: rtl/core/ips_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_pkg
// Shared codes for the idle power sequencer: event kinds, announce and helper
// command codes, configuration register indexes and stream field widths.
// ----------------------------------------------------------------------------
package ips_pkg;

  // event kinds carried on in_tuser
  localparam logic [2:0] EV_BUSY = 3'd0;
  localparam logic [2:0] EV_IDLE = 3'd1;
  localparam logic [2:0] EV_TICK = 3'd2;
  localparam logic [2:0] EV_ACK  = 3'd3;
  localparam logic [2:0] EV_NAK  = 3'd4;

  // announce codes
  localparam logic [1:0] ANN_NONE = 2'd0;
  localparam logic [1:0] ANN_DOWN = 2'd1;
  localparam logic [1:0] ANN_UP   = 2'd2;

  // helper command codes
  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_SUSPEND  = 2'd1;
  localparam logic [1:0] CMD_SHUTDOWN = 2'd2;

  // capability bits
  localparam int CAP_ONESHOT = 0;
  localparam int CAP_HELPER  = 1;
  localparam int CAP_SUSPEND = 2;
  localparam int CAP_SERVER  = 3;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_CAPS       = 3'd0;
  localparam logic [2:0] REG_IDLE_GRACE = 3'd1;
  localparam logic [2:0] REG_FLUSH_WAIT = 3'd2;
  localparam logic [2:0] REG_SUSP_DL    = 3'd3;
  localparam logic [2:0] REG_OFF_REPLY  = 3'd4;
  localparam logic [2:0] REG_OFF_DL     = 3'd5;
  localparam logic [2:0] REG_HOLDOFF    = 3'd6;

  localparam int CFG_AW      = 5;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;
  localparam int OUT_USED_W  = 19;

endpackage

// File: rtl/core/idle_power_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_power_sequencer
// Seven-state auto power sequencer driven by busy/idle/tick/ack/nak events.
// ----------------------------------------------------------------------------
// Each event transaction is decided by combinational logic: the state, timer and failure
// registers feed a single pass of decode logic whose result lands in the
// output register while the state registers take their next values. A new
// event is accepted every cycle; the output register holds a result while the
// downstream side stalls, and in_tready drops only while that held result is
// not being taken. The user must write timeout registers through the APB
// port only while no events are flowing; the block does not enforce this. A
// tick with an armed timer at one or zero acts as the current state's timeout.
module idle_power_sequencer #(
  parameter int TIMER_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // event input
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ips_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] resumed, [1] helper_write_fails
  input  logic [2:0]                     in_tuser,   // [2:0] event_kind
  // result output
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [2:0] power_state_out, [3] going_down, [5:4] announce,
  // [7:6] helper_command, [8] off_request, [9] exit_request,
  // [17:10] failures, [18] timer_running
  output logic [ips_pkg::OUT_DATA_W-1:0] out_tdata,
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ips_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  typedef enum logic [2:0] {
    ST_ACTIVE     = 3'd0,
    ST_IDLE       = 3'd1,
    ST_HOLDOFF    = 3'd2,
    ST_SUSP_WAIT  = 3'd3,
    ST_SUSPENDING = 3'd4,
    ST_OFF_REQ    = 3'd5,
    ST_OFF_WAIT   = 3'd6
  } pstate_t;

  localparam logic [63:0] TMAX = 64'((65'd1 << TIMER_BITS) - 65'd1);

  // saturating load of a 32-bit timeout into the timer
  function automatic logic [TIMER_BITS-1:0] tload(input logic [31:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    if (wide > TMAX) begin
      return {TIMER_BITS{1'b1}};
    end
    return TIMER_BITS'(wide);
  endfunction

  // configuration registers
  logic [3:0]  caps_r;
  logic [31:0] idle_grace_r, flush_wait_r, susp_dl_r, off_reply_r, off_dl_r, holdoff_r;

  // sequencer state
  pstate_t                 state_r, state_nxt;
  logic [TIMER_BITS-1:0]   remain_r, remain_nxt;
  logic                    armed_r, armed_nxt;
  logic [7:0]              fail_r, fail_nxt;
  logic                    claim_r, claim_nxt;

  // result register
  logic                    out_valid_r;
  logic [ips_pkg::OUT_USED_W-1:0] res_r, res_nxt;

  logic [2:0]  ev;
  logic        resumed, wfail;
  logic        in_acc, cfg_wr;
  logic        can_exit, can_susp, can_off, has_ability;
  logic [1:0]  ann, cmd;
  logic        offreq, exit_v;

  assign ev      = in_tuser;
  assign resumed = in_tdata[0];
  assign wfail   = in_tdata[1];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(ips_pkg::OUT_DATA_W - ips_pkg::OUT_USED_W)'(0), res_r};

  assign can_exit    = caps_r[ips_pkg::CAP_ONESHOT];
  assign can_susp    = caps_r[ips_pkg::CAP_HELPER] && caps_r[ips_pkg::CAP_SUSPEND];
  assign can_off     = caps_r[ips_pkg::CAP_HELPER] && !caps_r[ips_pkg::CAP_SUSPEND]
                       && caps_r[ips_pkg::CAP_SERVER];
  assign has_ability = can_exit || can_susp || can_off;

  always_comb begin
    logic       is_to;
    logic       handle;
    logic       fail;
    logic [2:0] hev;

    state_nxt  = state_r;
    remain_nxt = remain_r;
    armed_nxt  = armed_r;
    fail_nxt   = fail_r;
    claim_nxt  = claim_r;
    ann        = ips_pkg::ANN_NONE;
    cmd        = ips_pkg::CMD_NONE;
    offreq     = 1'b0;
    exit_v     = 1'b0;
    is_to      = 1'b0;
    handle     = 1'b0;
    fail       = 1'b0;
    hev        = ev;

    if (ev == ips_pkg::EV_TICK) begin
      if (armed_r) begin
        if (remain_r[TIMER_BITS-1:1] == '0) begin
          armed_nxt  = 1'b0;
          remain_nxt = '0;
          is_to      = 1'b1;
          handle     = 1'b1;
        end else begin
          remain_nxt = remain_r - TIMER_BITS'(1);
        end
      end
    end else if (ev <= ips_pkg::EV_NAK) begin
      handle = 1'b1;
    end
    if (is_to) begin
      hev = 3'd7;  // no real event code; timeout tracked by is_to
    end

    if (handle) begin
      case (state_r)
        ST_ACTIVE: begin
          if (hev == ips_pkg::EV_IDLE && has_ability) begin
            state_nxt = ST_IDLE; armed_nxt = 1'b1; remain_nxt = tload(idle_grace_r);
          end
        end
        ST_IDLE: begin
          if (hev == ips_pkg::EV_BUSY) begin
            state_nxt = ST_ACTIVE; armed_nxt = 1'b0; remain_nxt = '0;
          end else if (is_to) begin
            if (can_susp) begin
              claim_nxt = 1'b1; ann = ips_pkg::ANN_DOWN;
              state_nxt = ST_SUSP_WAIT; armed_nxt = 1'b1; remain_nxt = tload(flush_wait_r);
            end else if (!can_off && !caps_r[ips_pkg::CAP_SERVER]) begin
              state_nxt = ST_ACTIVE; armed_nxt = 1'b0; remain_nxt = '0;
              exit_v = can_exit;
            end else begin
              claim_nxt = 1'b1; ann = ips_pkg::ANN_DOWN;
              state_nxt = ST_OFF_REQ; armed_nxt = 1'b1; remain_nxt = tload(off_reply_r);
              offreq = 1'b1;
            end
          end
        end
        ST_HOLDOFF: begin
          if (hev == ips_pkg::EV_BUSY) begin
            state_nxt = ST_ACTIVE; armed_nxt = 1'b0; remain_nxt = '0;
          end else if (is_to) begin
            state_nxt = ST_IDLE; armed_nxt = 1'b1; remain_nxt = tload(idle_grace_r);
          end
        end
        ST_SUSP_WAIT: begin
          if (hev == ips_pkg::EV_BUSY) begin
            claim_nxt = 1'b0; ann = ips_pkg::ANN_UP;
            state_nxt = ST_ACTIVE; armed_nxt = 1'b0; remain_nxt = '0;
          end else if (is_to) begin
            if (!caps_r[ips_pkg::CAP_HELPER] || wfail) begin
              fail = 1'b1;
            end else begin
              cmd = ips_pkg::CMD_SUSPEND;
              state_nxt = ST_SUSPENDING; armed_nxt = 1'b1; remain_nxt = tload(susp_dl_r);
            end
          end
        end
        ST_SUSPENDING: begin
          if (is_to || hev == ips_pkg::EV_BUSY) begin
            if (!resumed) begin
              fail = is_to;
            end else begin
              fail_nxt  = '0;
              claim_nxt = 1'b0; ann = ips_pkg::ANN_UP;
              if (is_to) begin
                state_nxt = ST_IDLE; armed_nxt = 1'b1; remain_nxt = tload(idle_grace_r);
              end else begin
                state_nxt = ST_ACTIVE; armed_nxt = 1'b0; remain_nxt = '0;
              end
            end
          end
        end
        ST_OFF_REQ: begin
          if (hev == ips_pkg::EV_ACK) begin
            // one-shot without helper: the server alone cuts power
            if (!caps_r[ips_pkg::CAP_HELPER] && can_exit) begin
              state_nxt = ST_OFF_WAIT; armed_nxt = 1'b1; remain_nxt = tload(off_dl_r);
            end else if (!caps_r[ips_pkg::CAP_HELPER] || wfail) begin
              fail = 1'b1;
            end else begin
              cmd = ips_pkg::CMD_SHUTDOWN;
              state_nxt = ST_OFF_WAIT; armed_nxt = 1'b1; remain_nxt = tload(off_dl_r);
            end
          end else if (hev == ips_pkg::EV_NAK) begin
            claim_nxt = 1'b0; ann = ips_pkg::ANN_UP;
            state_nxt = ST_HOLDOFF; armed_nxt = 1'b1; remain_nxt = tload(holdoff_r);
          end else if (is_to) begin
            fail = 1'b1;
          end
        end
        ST_OFF_WAIT: begin
          fail = is_to;
        end
        default: begin
          state_nxt = ST_ACTIVE; armed_nxt = 1'b0; remain_nxt = '0;
        end
      endcase
    end

    if (fail) begin
      if (fail_r != 8'hFF) begin
        fail_nxt = fail_r + 8'd1;
      end
      if (can_exit) begin
        state_nxt = ST_ACTIVE; armed_nxt = 1'b0; remain_nxt = '0;
        exit_v = 1'b1;
      end else begin
        claim_nxt = 1'b0; ann = ips_pkg::ANN_UP;
        state_nxt = ST_HOLDOFF; armed_nxt = 1'b1; remain_nxt = tload(holdoff_r);
      end
    end

    res_nxt = {armed_nxt, fail_nxt, exit_v, offreq, cmd, ann, claim_nxt, state_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACTIVE;
      remain_r    <= '0;
      armed_r     <= 1'b0;
      fail_r      <= '0;
      claim_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r     <= state_nxt;
        remain_r    <= remain_nxt;
        armed_r     <= armed_nxt;
        fail_r      <= fail_nxt;
        claim_r     <= claim_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r       <= 4'd0;
      idle_grace_r <= 32'd600;
      flush_wait_r <= 32'd5;
      susp_dl_r    <= 32'd120;
      off_reply_r  <= 32'd10;
      off_dl_r     <= 32'd300;
      holdoff_r    <= 32'd600;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        ips_pkg::REG_CAPS:       caps_r       <= cfg_pwdata[3:0];
        ips_pkg::REG_IDLE_GRACE: idle_grace_r <= cfg_pwdata;
        ips_pkg::REG_FLUSH_WAIT: flush_wait_r <= cfg_pwdata;
        ips_pkg::REG_SUSP_DL:    susp_dl_r    <= cfg_pwdata;
        ips_pkg::REG_OFF_REPLY:  off_reply_r  <= cfg_pwdata;
        ips_pkg::REG_OFF_DL:     off_dl_r     <= cfg_pwdata;
        ips_pkg::REG_HOLDOFF:    holdoff_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      ips_pkg::REG_CAPS:       cfg_prdata = {28'd0, caps_r};
      ips_pkg::REG_IDLE_GRACE: cfg_prdata = idle_grace_r;
      ips_pkg::REG_FLUSH_WAIT: cfg_prdata = flush_wait_r;
      ips_pkg::REG_SUSP_DL:    cfg_prdata = susp_dl_r;
      ips_pkg::REG_OFF_REPLY:  cfg_prdata = off_reply_r;
      ips_pkg::REG_OFF_DL:     cfg_prdata = off_dl_r;
      ips_pkg::REG_HOLDOFF:    cfg_prdata = holdoff_r;
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // assertions
  a_active_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACTIVE |-> !armed_r)
    else $error("timer armed in active state");

  a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> remain_r == '0)
    else $error("disarmed timer holds a count");

  a_exit_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r[9] |-> res_r[2:0] == ST_ACTIVE && !res_r[18])
    else $error("exit without return to active");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> res_r[2:0] == state_r && res_r[18] == armed_r && res_r[17:10] == fail_r)
    else $error("result out of step with state");

endmodule

// File: bench/ips_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_tb_pkg
// Scoreboard for the idle power sequencer bench. It keeps its own copy of the
// sequencer state and the timeout registers, predicts the status report that
// each accepted event produces and compares the reports coming out of the block.
// ----------------------------------------------------------------------------
package ips_tb_pkg;
  import ips_pkg::*;

  typedef enum logic [2:0] {
    ST_ACTIVE     = 3'd0,
    ST_IDLE       = 3'd1,
    ST_HOLDOFF    = 3'd2,
    ST_SUSP_WAIT  = 3'd3,
    ST_SUSPENDING = 3'd4,
    ST_OFF_REQ    = 3'd5,
    ST_OFF_WAIT   = 3'd6
  } pstate_t;

  // what the current capabilities allow once idle grace runs out
  localparam int CAN_SUSPEND = 0;
  localparam int CAN_OFF     = 1;
  localparam int CAN_EXIT    = 2;

  // status report as packed on out_tdata, lowest field last
  typedef struct packed {
    logic       timer_on;
    logic [7:0] failures;
    logic       exit_req;
    logic       off_req;
    logic [1:0] cmd;
    logic [1:0] announce;
    logic       down;
    logic [2:0] state;
  } status_t;

  class power_scoreboard;
    logic [31:0] regs [7];
    pstate_t     state;
    logic [31:0] remaining;
    bit          armed;
    logic [7:0]  fails;
    bit          claim;
    logic [1:0]  ann;
    logic [1:0]  cmd;
    bit          offreq;
    bit          exitreq;

    status_t     due_reports [$];
    int unsigned errors;
    int unsigned events_seen;
    int unsigned effective;
    int unsigned reports_checked;
    bit [6:0]    states_seen;
    bit          saturated;

    function new();
      regs = '{32'd0, 32'd600, 32'd5, 32'd120, 32'd10, 32'd300, 32'd600};
      state     = ST_ACTIVE;
      remaining = '0;
      armed     = 1'b0;
      fails     = '0;
      claim     = 1'b0;
      states_seen = 7'b1;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      regs[idx] = (idx == REG_CAPS) ? {28'd0, val[3:0]} : val;
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      end
    endfunction

    function logic [2:0] ability();
      logic [3:0] caps;
      logic [2:0] c;
      caps = regs[REG_CAPS][3:0];
      c = '0;
      c[CAN_EXIT] = caps[CAP_ONESHOT];
      if (caps[CAP_HELPER]) begin
        if (caps[CAP_SUSPEND]) c[CAN_SUSPEND] = 1'b1;
        else if (caps[CAP_SERVER]) c[CAN_OFF] = 1'b1;
      end
      return c;
    endfunction

    function void enter(pstate_t s, bit arm, logic [31:0] ticks);
      state     = s;
      armed     = arm;
      remaining = arm ? ticks : '0;
    endfunction

    function void claim_down(bit down);
      claim = down;
      ann   = down ? ANN_DOWN : ANN_UP;
    endfunction

    function void leave();
      enter(ST_ACTIVE, 1'b0, '0);
      exitreq = 1'b1;
    endfunction

    function void fail_action();
      if (fails != 8'hFF) fails = fails + 8'd1;
      if (regs[REG_CAPS][CAP_ONESHOT]) begin
        leave();
      end else begin
        claim_down(1'b0);
        enter(ST_HOLDOFF, 1'b1, regs[REG_HOLDOFF]);
      end
    endfunction

    function bit helper_ok(logic [1:0] code, bit wfail);
      if (!regs[REG_CAPS][CAP_HELPER] || wfail) return 1'b0;
      cmd = code;
      return 1'b1;
    endfunction

    // tmo marks the expiry of the state timer; ev is then meaningless
    function void on_event(logic [2:0] ev, bit tmo, bit resumed, bit wfail);
      logic [2:0] c;
      bit busy, idle_ev, ack, nak;
      c       = ability();
      busy    = !tmo && ev == EV_BUSY;
      idle_ev = !tmo && ev == EV_IDLE;
      ack     = !tmo && ev == EV_ACK;
      nak     = !tmo && ev == EV_NAK;
      case (state)
        ST_ACTIVE: begin
          if (idle_ev && c != '0) enter(ST_IDLE, 1'b1, regs[REG_IDLE_GRACE]);
        end
        ST_IDLE: begin
          if (busy) begin
            enter(ST_ACTIVE, 1'b0, '0);
          end else if (tmo) begin
            if (c[CAN_SUSPEND]) begin
              claim_down(1'b1);
              enter(ST_SUSP_WAIT, 1'b1, regs[REG_FLUSH_WAIT]);
            end else if (!c[CAN_OFF] && !regs[REG_CAPS][CAP_SERVER]) begin
              if (c[CAN_EXIT]) leave();
              else enter(ST_ACTIVE, 1'b0, '0);
            end else begin
              claim_down(1'b1);
              enter(ST_OFF_REQ, 1'b1, regs[REG_OFF_REPLY]);
              offreq = 1'b1;
            end
          end
        end
        ST_HOLDOFF: begin
          if (busy) enter(ST_ACTIVE, 1'b0, '0);
          else if (tmo) enter(ST_IDLE, 1'b1, regs[REG_IDLE_GRACE]);
        end
        ST_SUSP_WAIT: begin
          if (busy) begin
            claim_down(1'b0);
            enter(ST_ACTIVE, 1'b0, '0);
          end else if (tmo) begin
            if (!helper_ok(CMD_SUSPEND, wfail)) fail_action();
            else enter(ST_SUSPENDING, 1'b1, regs[REG_SUSP_DL]);
          end
        end
        ST_SUSPENDING: begin
          if (tmo || busy) begin
            if (!resumed) begin
              if (tmo) fail_action();
            end else begin
              fails = '0;
              claim_down(1'b0);
              if (busy) enter(ST_ACTIVE, 1'b0, '0);
              else enter(ST_IDLE, 1'b1, regs[REG_IDLE_GRACE]);
            end
          end
        end
        ST_OFF_REQ: begin
          if (ack) begin
            // without a helper a one-shot run just waits for the power cut
            if (!regs[REG_CAPS][CAP_HELPER] && regs[REG_CAPS][CAP_ONESHOT])
              enter(ST_OFF_WAIT, 1'b1, regs[REG_OFF_DL]);
            else if (!helper_ok(CMD_SHUTDOWN, wfail)) fail_action();
            else enter(ST_OFF_WAIT, 1'b1, regs[REG_OFF_DL]);
          end else if (nak) begin
            claim_down(1'b0);
            enter(ST_HOLDOFF, 1'b1, regs[REG_HOLDOFF]);
          end else if (tmo) begin
            fail_action();
          end
        end
        ST_OFF_WAIT: begin
          if (tmo) fail_action();
        end
        default: enter(ST_ACTIVE, 1'b0, '0);
      endcase
    endfunction

    function status_t status_now();
      status_t s;
      s.state    = state;
      s.down     = claim;
      s.announce = ann;
      s.cmd      = cmd;
      s.off_req  = offreq;
      s.exit_req = exitreq;
      s.failures = fails;
      s.timer_on = armed;
      return s;
    endfunction

    // returns 1 when the event changed anything at all
    function bit note_event(logic [2:0] ev, bit resumed, bit wfail);
      status_t     before_s, after_s;
      logic [31:0] rem0;
      bit          changed;
      ann     = ANN_NONE;
      cmd     = CMD_NONE;
      offreq  = 1'b0;
      exitreq = 1'b0;
      before_s = status_now();
      rem0     = remaining;
      if (ev == EV_TICK) begin
        if (armed) begin
          if (remaining < 32'd2) begin
            armed     = 1'b0;
            remaining = '0;
            on_event(ev, 1'b1, resumed, wfail);
          end else begin
            remaining = remaining - 32'd1;
          end
        end
      end else if (ev <= EV_NAK) begin
        on_event(ev, 1'b0, resumed, wfail);
      end
      after_s = status_now();
      due_reports.push_back(after_s);
      states_seen[state] = 1'b1;
      if (fails == 8'hFF) saturated = 1'b1;
      events_seen++;
      changed = (after_s != before_s) || (remaining != rem0);
      if (changed) effective++;
      return changed;
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] d);
      status_t got, want;
      if (due_reports.size() == 0) begin
        errors++;
        $error("status report with no event outstanding: %h", d);
        return;
      end
      want = due_reports.pop_front();
      got  = d[OUT_USED_W-1:0];
      reports_checked++;
      compare("power_state_out", want.state,    got.state);
      compare("going_down",      want.down,     got.down);
      compare("announce",        want.announce, got.announce);
      compare("helper_command",  want.cmd,      got.cmd);
      compare("off_request",     want.off_req,  got.off_req);
      compare("exit_request",    want.exit_req, got.exit_req);
      compare("failures",        want.failures, got.failures);
      compare("timer_running",   want.timer_on, got.timer_on);
    endfunction
  endclass

endpackage

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives event transactions into idle_power_sequencer and checks every status
// report against the scoreboard's prediction. A short directed run walks the
// suspend, power-off, one-shot exit and failure paths; random phases follow,
// each with its own capabilities, timeout registers and flow-control pattern.
// ----------------------------------------------------------------------------
module testbench;
  import ips_pkg::*;
  import ips_tb_pkg::*;

  typedef enum {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_t;
  typedef enum {TMO_UNIT, TMO_SMALL, TMO_MIXED, TMO_EXTREME} tmo_mix_t;

  localparam logic [2:0] EV_UNUSED = 3'd5;  // first of the codes with no meaning

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;  // [0] resumed, [1] helper_write_fails
  logic [2:0]            in_tuser    = '0;  // [2:0] event_kind
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  // [2:0] state, [3] going_down, [5:4] announce, [7:6] helper_command,
  // [8] off_request, [9] exit_request, [17:10] failures, [18] timer_running
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  power_scoreboard sb;
  flow_t           flow          = FLOW_FREE;
  bit              stall_request = 1'b0;
  int unsigned     hold_left     = 0;
  int unsigned     long_holds    = 0;
  int unsigned     reg_writes    = 0;
  logic [31:0]     reg_plan [7];

  const string reg_names [7] = '{"capabilities", "idle_grace_ticks", "flush_wait_ticks",
                                 "suspend_deadline_ticks", "off_reply_ticks",
                                 "off_deadline_ticks", "retry_holdoff_ticks"};

  idle_power_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check each report, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata);
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_request) begin
      stall_request = 1'b0;
      hold_left = 300;
      long_holds++;
      out_tready <= 1'b0;
    end else begin
      case (flow)
        FLOW_SINK_STALLS: out_tready <= ($urandom_range(99) >= 88);
        FLOW_BOTH:        out_tready <= ($urandom_range(99) >= 13);
        default:          out_tready <= 1'b1;
      endcase
    end
  end

  task automatic send_event(input logic [2:0] ev, input bit resumed, input bit wfail,
                            output bit eff);
    in_tvalid <= 1'b1;
    in_tuser  <= ev;
    in_tdata  <= {{(IN_DATA_W-2){1'b0}}, wfail, resumed};
    do @(posedge clk); while (!in_tready);
    eff = sb.note_event(ev, resumed, wfail);
  endtask

  task automatic apb_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // waits for every report to come back, then writes and reads back reg_plan
  task automatic load_regs();
    logic [31:0] rd;
    in_tvalid <= 1'b0;
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      apb_access(1'b1, 3'(i), reg_plan[i], rd);
      sb.set_reg(3'(i), reg_plan[i]);
      reg_writes++;
      apb_access(1'b0, 3'(i), '0, rd);
      sb.compare(reg_names[i], sb.regs[i], rd);
    end
  endtask

  function automatic logic [31:0] pick_ticks(tmo_mix_t mix);
    int unsigned r;
    r = $urandom_range(9);
    case (mix)
      TMO_UNIT:  return 32'd1;
      TMO_SMALL: return $urandom_range(4);
      TMO_MIXED: begin
        if (r == 0) return 32'd0;
        if (r < 7) return $urandom_range(1, 8);
        if (r < 9) return $urandom_range(9, 60);
        return $urandom_range(61, 400);
      end
      default: begin
        case (r % 4)
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return 32'hFFFF_FFFE;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // mostly the events that move the current state on, with some noise
  function automatic logic [2:0] pick_event(int unsigned busy_pct);
    int unsigned r;
    if ($urandom_range(99) < 6) return 3'($urandom_range(7));
    r = $urandom_range(99);
    case (sb.state)
      ST_ACTIVE: begin
        if (r < 70) return EV_IDLE;
        if (r < 70 + busy_pct) return EV_BUSY;
        return EV_TICK;
      end
      ST_OFF_REQ: begin
        if (r < 35) return EV_ACK;
        if (r < 55) return EV_NAK;
        if (r < 55 + busy_pct) return EV_BUSY;
        return EV_TICK;
      end
      default: return (r < busy_pct) ? EV_BUSY : EV_TICK;
    endcase
  endfunction

  task automatic run_phase(input logic [3:0] caps, input tmo_mix_t mix, input flow_t f,
                           input int unsigned wfail_pct, input int unsigned resume_pct,
                           input int unsigned busy_pct, input int unsigned target,
                           input bit pressure);
    int unsigned tries, gap_pct, n;
    logic [2:0]  ev;
    bit          eff;
    tries = 0;
    reg_plan[REG_CAPS] = ($urandom() & ~32'hF) | {28'd0, caps};
    for (int i = 1; i < 7; i++) reg_plan[i] = pick_ticks(mix);
    load_regs();
    flow = f;
    gap_pct = (f == FLOW_SRC_GAPS) ? 88 : (f == FLOW_BOTH) ? 13 : 0;
    while (tries < target) begin
      n = 0;
      while ($urandom_range(99) < gap_pct) n++;
      if (n != 0) begin
        in_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
      end
      ev = pick_event(busy_pct);
      send_event(ev, $urandom_range(99) < resume_pct, $urandom_range(99) < wfail_pct, eff);
      tries++;
      if (pressure && tries == target / 2) stall_request = 1'b1;
    end
  endtask

  initial begin
    #5_000_000;
    $display("idle_power_sequencer test failed");
    $finish;
  end

  initial begin
    bit eff;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, no capabilities: nothing may react
    for (int k = 0; k < 3; k++) send_event(EV_UNUSED + 3'(k), 1'b1, 1'b1, eff);
    send_event(EV_TICK, 1'b0, 1'b0, eff);
    send_event(EV_ACK,  1'b1, 1'b0, eff);
    send_event(EV_NAK,  1'b0, 1'b1, eff);
    send_event(EV_BUSY, 1'b1, 1'b1, eff);
    send_event(EV_IDLE, 1'b0, 1'b0, eff);

    // suspend path: zero flush wait expires at once, huge deadline, resumed on busy
    reg_plan = '{(32'd1 << CAP_HELPER) | (32'd1 << CAP_SUSPEND), 32'd1, 32'd0,
                 32'hFFFF_FFFF, 32'd10, 32'd300, 32'd600};
    load_regs();
    send_event(EV_IDLE, 1'b0, 1'b0, eff);
    send_event(EV_TICK, 1'b0, 1'b0, eff);
    send_event(EV_TICK, 1'b0, 1'b0, eff);
    send_event(EV_TICK, 1'b0, 1'b0, eff);
    send_event(EV_BUSY, 1'b1, 1'b0, eff);

    // one-shot with power server and no helper: ack, then deadline failure exits
    reg_plan = '{(32'd1 << CAP_ONESHOT) | (32'd1 << CAP_SERVER), 32'd1, 32'd5,
                 32'd120, 32'd10, 32'd1, 32'd600};
    load_regs();
    send_event(EV_IDLE, 1'b0, 1'b0, eff);
    send_event(EV_TICK, 1'b0, 1'b0, eff);
    send_event(EV_ACK,  1'b0, 1'b0, eff);
    send_event(EV_TICK, 1'b0, 1'b0, eff);

    // helper and server: refusal, holdoff, then a failed shutdown command
    reg_plan = '{(32'd1 << CAP_HELPER) | (32'd1 << CAP_SERVER), 32'd1, 32'd5,
                 32'd120, 32'd10, 32'd300, 32'd1};
    load_regs();
    send_event(EV_IDLE, 1'b0, 1'b0, eff);
    send_event(EV_TICK, 1'b0, 1'b0, eff);
    send_event(EV_NAK,  1'b0, 1'b0, eff);
    send_event(EV_TICK, 1'b0, 1'b0, eff);
    send_event(EV_TICK, 1'b0, 1'b0, eff);
    send_event(EV_ACK,  1'b0, 1'b1, eff);

    run_phase(4'b0110, TMO_SMALL,   FLOW_FREE,        25, 50, 12, 120, 1'b0);
    run_phase(4'b1010, TMO_SMALL,   FLOW_SRC_GAPS,    25, 50, 12, 120, 1'b0);
    run_phase(4'b1001, TMO_MIXED,   FLOW_SINK_STALLS, 25, 50, 12, 120, 1'b0);
    run_phase(4'b1111, TMO_SMALL,   FLOW_BOTH,        30, 40, 12, 120, 1'b0);
    run_phase(4'b0011, TMO_SMALL,   FLOW_FREE,        25, 50, 12, 120, 1'b1);
    // failure storm: no resume, so the failure count climbs to saturation
    run_phase(4'b0110, TMO_UNIT,    FLOW_FREE,        85,  0,  2, 850, 1'b0);
    run_phase(4'($urandom_range(15)), TMO_MIXED, FLOW_SINK_STALLS, 30, 50, 12, 120, 1'b0);
    run_phase(4'($urandom_range(15)), TMO_MIXED, FLOW_SRC_GAPS,    30, 50, 12, 120, 1'b0);
    run_phase(4'b1110, TMO_SMALL,   FLOW_BOTH,        25, 50, 12, 120, 1'b0);
    run_phase(4'($urandom_range(15)), TMO_EXTREME, FLOW_FREE,      25, 50, 12, 120, 1'b0);

    in_tvalid <= 1'b0;
    flow = FLOW_FREE;
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d events (%0d with an effect), checked %0d reports, %0d register writes.",
             sb.events_seen, sb.effective, sb.reports_checked, reg_writes);
    $display("States reached %b, failure count saturated %0d, long output stalls %0d.",
             sb.states_seen, sb.saturated, long_holds);
    if (sb.errors == 0) begin
      $display("idle_power_sequencer test passed");
    end else begin
      $display("idle_power_sequencer test failed");
    end
    $finish;
  end

endmodule
